// File: src/rhkt_pkg.sv
// Shared constants, types and codes for the Robin Hood key table.
package rhkt_pkg;

  localparam int TABLE_SIZE    = 256;
  localparam int ADDR_W        = $clog2(TABLE_SIZE);
  localparam int MAX_KEY_BYTES = 16;
  localparam int LEN_W         = 5;
  localparam int DIST_W        = 8;
  localparam int CNT_W         = ADDR_W + 1;
  localparam int VAL_W         = 32;

  localparam logic [7:0] HASH_MUL = 8'h92;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL
  } state_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_HIT      = 2'd2,
    ST_MISS     = 2'd3
  } status_t;

  typedef struct packed {
    logic [63:0]        key_low;
    logic [63:0]        key_high;
    logic [LEN_W-1:0]   key_len;
    logic [VAL_W-1:0]   value;
    logic [DIST_W-1:0]  probe_dist;
  } slot_t;

endpackage

// File: src/robin_hood_key_table.sv
// Top level of the Robin Hood key table: sequencer, config register, result word.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+---------------------------
//  request | start, busy, in_req_type, in_key_low,        | taken when start && !busy
//          | in_key_high, in_key_len, in_new_value        |
//  result  | out_valid, out_status, out_found_value       | one-cycle strobe, no stall
//  config  | cfg_valid, cfg_ready, cfg_data (table_mask)  | taken when valid && ready
//
// Walk: every request walks its probe chain one slot at a time (read, then
// evaluate on the registered memory word), through the one read port of the
// slot memory. Busy stays high for the whole walk and falls as the result word
// is shown, so the next request can be taken then. A walk stopped by the bound
// ends in the read state with no memory read; an insert refused for a full
// table is answered from idle, busy staying low. At most mask+1 slots are visited.
// Reset: synchronous, active low; clears all valid flags at once, the entry
// count, and sets table_mask to 255. No clearing pass is needed.
// Stalls: busy is high for the whole walk; cfg_ready is low while busy or
// start is high; the receiver cannot stall the result word, which is shown
// for exactly one cycle.
module robin_hood_key_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [63:0]                 in_key_low,
  input  logic [63:0]                 in_key_high,
  input  logic [rhkt_pkg::LEN_W-1:0]  in_key_len,
  input  logic signed [31:0]          in_new_value,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic signed [31:0]          out_found_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_data
);
  import rhkt_pkg::*;

  state_t              state_r, state_nxt;
  req_t                req_r, req_nxt;
  slot_t               car_r, car_nxt;       // carried entry; lookup keeps the query here
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;           // slots visited so far
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;       // entries held
  logic [7:0]          mask_cfg_r;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [VAL_W-1:0]    out_val_r, out_val_nxt;

  logic [7:0]          sm1, sm2, sm3;
  logic [ADDR_W-1:0]   mask;
  logic [63:0]         h_low, h_high;
  logic [LEN_W-1:0]    h_len;
  logic [ADDR_W-1:0]   h_idx;

  logic                rd_en, rd_valid, wr_en;
  slot_t               rd_data;
  logic                key_match;
  logic [ADDR_W-1:0]   idx_inc;

  // Smear the mask down so it is always a power of two minus one.
  assign sm1  = mask_cfg_r | (mask_cfg_r >> 1);
  assign sm2  = sm1 | (sm1 >> 2);
  assign sm3  = sm2 | (sm2 >> 4);
  assign mask = sm3[ADDR_W-1:0];

  rhkt_key_hash u_hash (
    .key_low   (in_key_low),
    .key_high  (in_key_high),
    .key_len   (in_key_len),
    .mask      (mask),
    .norm_low  (h_low),
    .norm_high (h_high),
    .norm_len  (h_len),
    .home_idx  (h_idx)
  );

  rhkt_slot_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (idx_r),
    .rd_valid (rd_valid),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (idx_r),
    .wr_data  (car_r)
  );

  assign key_match = (rd_data.key_len == car_r.key_len) &&
                     (rd_data.key_low == car_r.key_low) &&
                     (rd_data.key_high == car_r.key_high);
  assign idx_inc   = (idx_r + ADDR_W'(1)) & mask;

  // Config register; written only while idle and no request is offered.
  assign cfg_ready = !busy && !start;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_cfg_r <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      mask_cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    car_r        <= car_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    car_nxt        = car_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // Latch the normalized key and home slot.
          req_nxt            = req_t'(in_req_type);
          car_nxt.key_low    = h_low;
          car_nxt.key_high   = h_high;
          car_nxt.key_len    = h_len;
          car_nxt.value      = in_new_value;
          car_nxt.probe_dist = '0;
          idx_nxt            = h_idx;
          n_nxt              = '0;
          if ((req_t'(in_req_type) == REQ_INSERT) && (cnt_r > {1'b0, mask})) begin
            // Drop: table already holds at least mask+1 entries.
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FULL;
            out_val_nxt    = '0;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        if (n_r > {1'b0, mask}) begin
          // Walk bound reached.
          out_valid_nxt  = 1'b1;
          out_status_nxt = (req_r == REQ_INSERT) ? ST_FULL : ST_MISS;
          out_val_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (req_r == REQ_INSERT) begin
          if (!rd_valid) begin
            // Empty slot: place the carried entry.
            wr_en          = 1'b1;
            cnt_nxt        = cnt_r + CNT_W'(1);
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_INSERTED;
            out_val_nxt    = '0;
            state_nxt      = S_IDLE;
          end else begin
            if (car_r.probe_dist > rd_data.probe_dist) begin
              // Richer resident: swap and carry it on.
              wr_en   = 1'b1;
              car_nxt = rd_data;
            end
            car_nxt.probe_dist = (car_nxt.probe_dist == '1) ? car_nxt.probe_dist
                                 : car_nxt.probe_dist + DIST_W'(1);
            idx_nxt   = idx_inc;
            n_nxt     = n_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end else begin
          if (!rd_valid || (n_r > {1'b0, rd_data.probe_dist})) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_MISS;
            out_val_nxt    = '0;
            state_nxt      = S_IDLE;
          end else if (key_match) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_HIT;
            out_val_nxt    = rd_data.value;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            n_nxt     = n_r + CNT_W'(1);
            state_nxt = S_READ;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_val_r;

  // Entry count never passes the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_SIZE))
    else $error("entry count above table size");

  // An accepted request is either in flight or answered at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r))
    else $error("request accepted without progress");

  // A successful insert grows the count by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_INSERTED) |->
      cnt_r == CNT_W'($past(cnt_r) + CNT_W'(1)))
    else $error("insert without count update");

  // Evaluate always follows a read.
  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $past(state_r) == S_READ)
    else $error("evaluate without read");

endmodule

// File: src/rhkt_key_hash.sv
// Key normalization and home slot hash.
module rhkt_key_hash (
  input  logic [63:0]                  key_low,
  input  logic [63:0]                  key_high,
  input  logic [rhkt_pkg::LEN_W-1:0]   key_len,
  input  logic [rhkt_pkg::ADDR_W-1:0]  mask,
  output logic [63:0]                  norm_low,
  output logic [63:0]                  norm_high,
  output logic [rhkt_pkg::LEN_W-1:0]   norm_len,
  output logic [rhkt_pkg::ADDR_W-1:0]  home_idx
);
  import rhkt_pkg::*;

  logic [127:0] full_key;
  logic [127:0] kept_key;
  logic [7:0]   prod;
  logic [7:0]   hash_lo;

  assign full_key = {key_high, key_low};
  // saturate long lengths
  assign norm_len = (key_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : key_len;

  // drop bytes at or beyond the length
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      kept_key[j*8 +: 8] = (LEN_W'(j) < norm_len) ? full_key[j*8 +: 8] : 8'h00;
    end
  end

  assign norm_low  = kept_key[63:0];
  assign norm_high = kept_key[127:64];

  // only the low byte of the hash reaches the index
  assign prod     = kept_key[7:0] * HASH_MUL;
  assign hash_lo  = prod ^ kept_key[15:8];
  assign home_idx = hash_lo[ADDR_W-1:0] & mask;

endmodule

// File: src/rhkt_slot_mem.sv
// Slot store: entry memory with registered read and per-slot valid flags.
module rhkt_slot_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [rhkt_pkg::ADDR_W-1:0]  rd_addr,
  output logic                         rd_valid,
  output rhkt_pkg::slot_t              rd_data,
  input  logic                         wr_en,
  input  logic [rhkt_pkg::ADDR_W-1:0]  wr_addr,
  input  rhkt_pkg::slot_t              wr_data
);
  import rhkt_pkg::*;

  slot_t                 mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] valid_r;
  logic                  rd_valid_r;
  slot_t                 rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (rd_en) rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_valid = rd_valid_r;
  assign rd_data  = rd_data_r;

endmodule
